// ===== rtl/duplicate_value_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Duplicate value filter assertion macros
// Concurrent assertion shorthands for the filter's RTL, used by the seen-value table.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_VALUE_FILTER_ASSERT_SVH
`define DUPLICATE_VALUE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dvf_pkg.sv =====
// ----------------------------------------------------------------------------
// Duplicate value filter package
// Types and fixed widths shared by the filter's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dvf_pkg;

   // Width of one list element.
   localparam int VALUE_W = 32;

   // One result transfer as produced by the lookup table engine.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      keep;
      logic                      last;
      logic                      overflow;
   } dvf_result_type;

endpackage

// ===== rtl/dvf_table.sv =====
// ----------------------------------------------------------------------------
// Duplicate value filter seen-value table
// Holds the values seen in the current list in a synchronous memory, scans
// it one entry per cycle for each new value and records first occurrences while there is room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "duplicate_value_filter_assert.svh"

module dvf_table #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [dvf_pkg::VALUE_W-1:0] start_value,
   input  logic                              start_last,
   input  logic                              res_take,
   output logic                              idle,
   output logic                              res_valid,
   output dvf_pkg::dvf_result_type           result
);

   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [dvf_pkg::VALUE_W-1:0]        seen_mem [MAX_ITEMS];
   logic [dvf_pkg::VALUE_W-1:0]        mem_q_ff;

   logic [1:0]                         state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   rd_idx_ff, rd_idx_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic                               hit_ff, hit_in;
   logic signed [dvf_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               last_ff, last_in;

   logic scan;
   logic match;
   logic rd_issue;
   logic scan_end;
   logic table_full;
   logic finish;
   logic mem_we;

   // The scan ends on a match, or once no further read is issued: at that
   // point the last pending entry, if any, is being compared.
   assign scan       = (state_ff == ST_SCAN);
   assign match      = rd_pend_ff && (mem_q_ff == value_ff);
   assign rd_issue   = scan && !match && (rd_idx_ff < count_ff);
   assign scan_end   = scan && (match || !rd_issue);
   assign table_full = (count_ff == CNT_W'(MAX_ITEMS));
   assign finish     = (state_ff == ST_DONE) && res_take;
   assign mem_we     = finish && !hit_ff && !table_full;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      rd_pend_in = rd_issue;
      hit_in     = hit_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in  = start_value;
               last_in   = start_last;
               rd_idx_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (scan_end) begin
               hit_in   = match;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               if (last_ff) begin
                  count_in = '0;
               end else if (mem_we) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      hit_ff    <= hit_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   // Entries are written only at the fill count and read only below it.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seen_mem[count_ff[IDX_W-1:0]] <= value_ff;
      end
      if (rd_issue) begin
         mem_q_ff <= seen_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   assign idle            = (state_ff == ST_IDLE);
   assign res_valid       = (state_ff == ST_DONE);
   assign result.value    = value_ff;
   assign result.keep     = !hit_ff;
   assign result.last     = last_ff;
   assign result.overflow = !hit_ff && table_full;

   `DVF_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ITEMS), "fill count beyond table depth")
   `DVF_ASSERT_SAME(a_scan_bound, clock, reset, scan, rd_idx_ff <= count_ff, "scan index beyond fill count")
   `DVF_ASSERT_NEXT(a_last_clears, clock, reset, finish && last_ff, count_ff == '0, "table not cleared after final element")
   `DVF_ASSERT_NEXT(a_record, clock, reset, mem_we && !last_ff, count_ff == $past(count_ff) + 1'b1, "new value not recorded")

endmodule

// ===== rtl/duplicate_value_filter.sv =====
// ----------------------------------------------------------------------------
// Duplicate value filter
// Marks each list element as kept on its first occurrence in the list or
// dropped when it repeats an earlier element.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid / req_stall  req_value, req_last
//  rsp_      out        rsp_valid / rsp_stall  rsp_value_out, rsp_keep,
//                                              rsp_last_out, rsp_overflow
//
// The scan of the seen-value memory reads one entry per cycle: a new element
// is compared with every value already recorded in its list, while a repeat
// stops at its first match, so the time from one request transfer to the
// next grows with the fill count, up to a full table of MAX_ITEMS entries.
// Reset clears the fill count at once, so no clearing pass is needed.
// The result register lets the next element be scanned while a result waits
// on rsp_stall; the table waits only when a second result is ready first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module duplicate_value_filter #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [dvf_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [dvf_pkg::VALUE_W-1:0] rsp_value_out,
   output logic                               rsp_keep,
   output logic                               rsp_last_out,
   output logic                               rsp_overflow
);

   logic                    tbl_idle;
   logic                    tbl_res_valid;
   dvf_pkg::dvf_result_type tbl_result;
   logic                    req_xfer;
   logic                    res_take;

   logic                    rsp_valid_ff, rsp_valid_in;
   dvf_pkg::dvf_result_type rsp_data_ff, rsp_data_in;

   // The table takes a new element only when its previous one is finished.
   assign req_stall = !tbl_idle;
   assign req_xfer  = req_valid && !req_stall;

   dvf_table #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer),
      .start_value (req_value),
      .start_last  (req_last),
      .res_take    (res_take),
      .idle        (tbl_idle),
      .res_valid   (tbl_res_valid),
      .result      (tbl_result)
   );

   // A finished result moves into the output register whenever that register
   // is empty or its current content leaves in this same cycle.
   assign res_take = tbl_res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = tbl_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_data_ff.value;
   assign rsp_keep      = rsp_data_ff.keep;
   assign rsp_last_out  = rsp_data_ff.last;
   assign rsp_overflow  = rsp_data_ff.overflow;

endmodule

// ===== tb/tb_duplicate_value_filter.sv =====
// ----------------------------------------------------------------------------
// Duplicate value filter testbench
// Streams lists of signed values through the filter, predicts the kept,
// dropped and overflow marks of every element with a local copy of the
// seen-value table, and checks each result transfer field by field against
// the oldest outstanding prediction while both sides insert random idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_duplicate_value_filter;

   // The table depth of the instance; the predictor keeps a table of the
   // same size.
   localparam int TABLE_DEPTH = 64;

   // A transfer gap longer than this many cycles means the block has hung.
   // The limit lies well above the slowest element's scan, the longest idle
   // bursts on both sides and the long receiver hold-off taken together.
   localparam int QUIET_LIMIT = 3000;

   // Cycles to keep watching after the last expected result has arrived.
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;

   localparam logic signed [dvf_pkg::VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
   localparam logic signed [dvf_pkg::VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [dvf_pkg::VALUE_W-1:0] req_value = '0;
   logic                               req_last = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [dvf_pkg::VALUE_W-1:0] rsp_value_out;
   logic                               rsp_keep;
   logic                               rsp_last_out;
   logic                               rsp_overflow;

   // Predicted results, oldest first, waiting for their result transfer.
   dvf_pkg::dvf_result_type pending_results[$];

   // The predictor's own copy of the seen-value table.
   logic signed [dvf_pkg::VALUE_W-1:0] seen_table[TABLE_DEPTH];
   int                                 seen_fill = 0;

   int  mismatch_count = 0;
   int  checked_results = 0;
   int  sent_items = 0;

   // Idle controls. The tests switch random idling on and off per list;
   // rsp_hold_cycles asks the receiver for one long hold-off.
   bit  send_gaps_en = 1'b0;
   bit  rsp_gaps_en = 1'b0;
   int  rsp_hold_cycles = 0;

   duplicate_value_filter #(
      .MAX_ITEMS(TABLE_DEPTH)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value_out(rsp_value_out),
      .rsp_keep     (rsp_keep),
      .rsp_last_out (rsp_last_out),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      forever begin
         #1 clock = ~clock;
      end
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Works out the result of one accepted element and updates the table.
   // A new value is recorded while there is room; once the table is full a
   // new value is still kept but flagged as overflow and left unrecorded.
   // The final element of a list empties the table after it is classified.
   function automatic dvf_pkg::dvf_result_type classify_value(
      input logic signed [dvf_pkg::VALUE_W-1:0] value,
      input logic                               last
   );
      dvf_pkg::dvf_result_type res;
      bit                      found;
      found = 1'b0;
      for (int i = 0; i < seen_fill; i++) begin
         if (seen_table[i] === value) begin
            found = 1'b1;
         end
      end
      res.value    = value;
      res.keep     = !found;
      res.last     = last;
      res.overflow = 1'b0;
      if (!found) begin
         if (seen_fill < TABLE_DEPTH) begin
            seen_table[seen_fill] = value;
            seen_fill++;
         end else begin
            res.overflow = 1'b1;
         end
      end
      if (last) begin
         seen_fill = 0;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------

   // Offers one element and returns at the rising edge where it is taken.
   // The inputs change only at falling edges. Valid stays high after the
   // transfer, so back-to-back elements need no extra assignment; an idle
   // burst, when one is drawn, drops valid before the next element.
   task automatic send_item(input logic signed [dvf_pkg::VALUE_W-1:0] value,
                            input logic last);
      @(negedge clock);
      if (send_gaps_en && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = value;
      req_last  = last;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_results.push_back(classify_value(value, last));
      sent_items++;
   endtask

   // Draws an element value: half the time a full random pattern, otherwise small
   // numbers around zero and the extremes of the signed range.
   function automatic logic signed [dvf_pkg::VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel < 4) begin
         return $urandom;
      end
      if (sel < 6) begin
         return $urandom_range(0, 16) - 8;
      end
      if (sel == 6) begin
         return $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
      end
      return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
   endfunction

   // ------------------------------------------------------------------------
   // Receiver
   // ------------------------------------------------------------------------

   // Drives rsp_stall at falling edges. A requested hold-off has priority;
   // otherwise random bursts of stalled cycles are drawn while receiver
   // idling is enabled.
   initial begin
      int burst_left;
      burst_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall = 1'b1;
            rsp_hold_cycles--;
         end else if (burst_left > 0) begin
            rsp_stall = 1'b1;
            burst_left--;
         end else if (rsp_gaps_en && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            burst_left = $urandom_range(1, 16) - 1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("[%0t] result %0d: %s mismatch, expected %h, got %h",
               $realtime, checked_results, what, want, got);
      mismatch_count++;
   endtask

   // Every result transfer is compared with the oldest prediction.
   initial begin
      dvf_pkg::dvf_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transfer", '0, rsp_value_out);
            end else begin
               want = pending_results.pop_front();
               if (rsp_value_out !== want.value) begin
                  report_mismatch("value", want.value, rsp_value_out);
               end
               if (rsp_keep !== want.keep) begin
                  report_mismatch("keep", 32'(want.keep), 32'(rsp_keep));
               end
               if (rsp_last_out !== want.last) begin
                  report_mismatch("last", 32'(want.last), 32'(rsp_last_out));
               end
               if (rsp_overflow !== want.overflow) begin
                  report_mismatch("overflow", 32'(want.overflow), 32'(rsp_overflow));
               end
            end
            checked_results++;
         end
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
      $display("duplicate_value_filter regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Extremes of the value range, single-bit differences, duplicates of
   // several of them, a one-element list and a list made of one repeated value. Values
   // that recur right after a final element must be kept again, since the
   // table is emptied at the end of every list.
   task automatic test_directed_extremes();
      send_gaps_en = 1'b0;
      rsp_gaps_en  = 1'b0;
      send_item(32'sd0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(MAX_VALUE, 1'b0);
      send_item(MIN_VALUE, 1'b0);
      send_item(32'sd1, 1'b0);
      // The sign bit alone tells these two apart.
      send_item(32'sh8000_0001, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(MIN_VALUE, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(32'sh5555_5555, 1'b0);
      send_item(32'shAAAA_AAAA, 1'b0);
      send_item(32'shAAAA_AAAA, 1'b1);
      // A list of one element that was seen in the previous list.
      send_item(-32'sd1, 1'b1);
      send_item(MAX_VALUE, 1'b0);
      send_item(MAX_VALUE, 1'b0);
      send_item(MAX_VALUE, 1'b1);
   endtask

   // First a list that fills the table exactly and ends there, which must
   // never overflow. Then a list that runs past a full table: new values
   // are kept with overflow set, a repeat of an unrecorded value overflows
   // again, a repeat of a recorded value is dropped without overflow, and
   // the final element arrives while the table is full.
   task automatic test_table_full();
      logic signed [dvf_pkg::VALUE_W-1:0] extra;
      send_gaps_en = 1'b0;
      rsp_gaps_en  = 1'b1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(i * 32'sd7919 - 32'sd100000, i == TABLE_DEPTH - 1);
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(MIN_VALUE + i, 1'b0);
      end
      extra = 32'sh1234_5678;
      send_item(extra, 1'b0);
      send_item(extra, 1'b0);
      send_item(MIN_VALUE, 1'b0);
      send_item(MIN_VALUE + TABLE_DEPTH - 1, 1'b0);
      send_item(MAX_VALUE, 1'b1);
      // The table is empty again, so the unrecorded value is simply new.
      send_item(extra, 1'b0);
      send_item(extra, 1'b1);
   endtask

   // The receiver stops for a long stretch while the sender keeps offering
   // elements back to back, so the result register and the scan both fill
   // and the block has to stall its input.
   task automatic test_backpressure();
      send_gaps_en    = 1'b0;
      rsp_gaps_en     = 1'b0;
      rsp_hold_cycles = 300;
      for (int i = 0; i < 24; i++) begin
         send_item($urandom_range(0, 7) - 4, i == 23);
      end
   endtask

   // Random lists. Most are short and drawn from a small pool of values so
   // that duplicates are frequent; some are medium sized, and a few are long
   // with mostly fresh values so that the table fills and overflows. With
   // allow_idle set, each list draws its own idle settings for both sides,
   // which leaves stretches with and without idling.
   task automatic test_random_lists(input int item_goal, input bit allow_idle);
      logic signed [dvf_pkg::VALUE_W-1:0] pool[$];
      logic signed [dvf_pkg::VALUE_W-1:0] value;
      int                                 first_item;
      int                                 list_len;
      int                                 kind;
      int                                 fresh_odds;
      first_item = sent_items;
      while (sent_items - first_item < item_goal) begin
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            list_len   = $urandom_range(1, 16);
            fresh_odds = 1;
         end else if (kind < 19) begin
            list_len   = $urandom_range(17, 48);
            fresh_odds = 2;
         end else begin
            list_len   = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 16);
            fresh_odds = 9;
         end
         pool.delete();
         repeat ($urandom_range(1, list_len / 2 + 2)) pool.push_back(pick_value());
         send_gaps_en = allow_idle && ($urandom_range(0, 3) != 0);
         rsp_gaps_en  = allow_idle && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < list_len; i++) begin
            if ($urandom_range(0, 9) < fresh_odds) begin
               value = (fresh_odds > 2) ? $urandom : pick_value();
            end else begin
               value = pool[$urandom_range(0, pool.size() - 1)];
            end
            send_item(value, i == list_len - 1);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_directed_extremes();
      test_table_full();
      test_backpressure();
      test_random_lists(600, 1'b1);
      // The last part of the run has no idling on either side.
      test_random_lists(100, 1'b0);

      @(negedge clock);
      req_valid = 1'b0;
      send_gaps_en = 1'b0;
      rsp_gaps_en  = 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("duplicate_value_filter regression: pass");
      end else begin
         $display("duplicate_value_filter regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dvf_pkg.sv
rtl/dvf_table.sv
rtl/duplicate_value_filter.sv
tb/tb_duplicate_value_filter.sv
